@@ design/pam_pkg.sv @@
// ----------------------------------------------------------------------------
// pam_pkg
// Shared constants, command codes and types of the polynomial add/multiply unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pam_pkg;

	// capacity of each coefficient store
	localparam int MAX_TERMS   = 32;
	localparam int IDX_W       = $clog2(MAX_TERMS);
	localparam int LEN_W       = $clog2(MAX_TERMS + 1);

	// field widths
	localparam int ACTION_W    = 2;
	localparam int COEF_W      = 16;
	localparam int VALUE_W     = 36;
	localparam int POW_W       = 6;

	// datapath widths
	localparam int TERM_W      = 2 * COEF_W;
	localparam int ACC_W       = TERM_W + LEN_W;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// action codes on the input channel
	localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SUM    = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_PROD   = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD_A,
		OP_LOAD_B,
		OP_SUM,
		OP_PROD
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic                     restart;
		logic signed [COEF_W-1:0] coef;
	} cmd_t;

endpackage

@@ design/pam_in_if.sv @@
// ----------------------------------------------------------------------------
// pam_in_if
// Command channel: load, sum and product beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pam_in_if;
	import pam_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ACTION_W-1:0]      action;
	logic                     restart;
	logic signed [COEF_W-1:0] coef;

	modport source (output valid, action, restart, coef, input ready);
	modport sink   (input valid, action, restart, coef, output ready);

endinterface

@@ design/pam_out_if.sv @@
// ----------------------------------------------------------------------------
// pam_out_if
// Result channel: one coefficient per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pam_out_if;
	import pam_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [POW_W-1:0]          power;
	logic                      last;
	logic                      dropped;

	modport source (output valid, value, power, last, dropped, input ready);
	modport sink   (input valid, value, power, last, dropped, output ready);

endinterface

@@ design/pam_ram.sv @@
// ----------------------------------------------------------------------------
// pam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/pam_front.sv @@
// ----------------------------------------------------------------------------
// pam_front
// Accepts command beats, decodes the action and hands commands to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pam_front (
	input  logic          clk,
	input  logic          arst_n,
	pam_in_if.sink        cmd,
	input  logic          q_full,
	output logic          q_push,
	output pam_pkg::cmd_t q_cmd
);
	import pam_pkg::*;

	logic v_s1;
	cmd_t cmd_s1;
	cmd_t dec;

	// decode action code into internal op
	always_comb begin
		dec.restart = cmd.restart;
		dec.coef    = cmd.coef;
		unique case (cmd.action)
			ACT_LOAD_A: dec.op = OP_LOAD_A;
			ACT_LOAD_B: dec.op = OP_LOAD_B;
			ACT_SUM:    dec.op = OP_SUM;
			ACT_PROD:   dec.op = OP_PROD;
			default:    dec.op = OP_SUM;
		endcase
	end

	assign q_push    = v_s1 && !q_full;
	assign q_cmd     = cmd_s1;
	assign cmd.ready = !v_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= dec;
		end
	end

endmodule

@@ design/pam_queue.sv @@
// ----------------------------------------------------------------------------
// pam_queue
// Short command queue decoupling the front from the execution back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pam_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pam_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output pam_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import pam_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

@@ design/pam_engine.sv @@
// ----------------------------------------------------------------------------
// pam_engine
// Back end: coefficient stores, lengths, shared multiply-accumulate sequencer
// and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pam_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  pam_pkg::cmd_t q_cmd,
	output logic          q_pop,
	pam_out_if.source     res
);
	import pam_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	localparam logic signed [ACC_W-1:0] ACC_HI =
		{{(ACC_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_LO =
		{{(ACC_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

	state_t                    state_q;
	logic [LEN_W-1:0]          len_a_q;
	logic [LEN_W-1:0]          len_b_q;
	logic                      ovf_q;
	logic                      prod_q;
	logic                      empty_q;
	logic [POW_W-1:0]          n_q;
	logic [POW_W-1:0]          k_q;
	logic [IDX_W-1:0]          i_q;
	logic [IDX_W-1:0]          hi_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic                      v_s1;
	logic                      ma_s1;
	logic                      mb_s1;
	logic                      prod_s1;
	logic                      v_s2;
	logic signed [TERM_W-1:0]  term_s2;

	logic                      out_v_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [POW_W-1:0]          out_power_q;
	logic                      out_last_q;
	logic                      out_dropped_q;

	logic                      load_a;
	logic                      load_b;
	logic [LEN_W-1:0]          eff_a;
	logic [LEN_W-1:0]          eff_b;
	logic                      full_a;
	logic                      full_b;
	logic                      we_a;
	logic                      we_b;
	logic [IDX_W-1:0]          raddr_a;
	logic [IDX_W-1:0]          raddr_b;
	logic [COEF_W-1:0]         rdata_a;
	logic [COEF_W-1:0]         rdata_b;
	logic signed [COEF_W-1:0]  a_s1;
	logic signed [COEF_W-1:0]  b_s1;
	logic signed [COEF_W-1:0]  sa;
	logic signed [COEF_W-1:0]  sb;
	logic [POW_W-1:0]          la_p;
	logic [POW_W-1:0]          lb_p;
	logic [POW_W-1:0]          n_new;
	logic [POW_W-1:0]          lo_p;
	logic [POW_W-1:0]          hi_p;
	logic                      is_last;
	logic                      slot_free;

	function automatic logic signed [VALUE_W-1:0] sat_value(
		input logic signed [ACC_W-1:0] a);
		logic signed [VALUE_W-1:0] r;
		if (a > ACC_HI) begin
			r = {1'b0, {(VALUE_W - 1){1'b1}}};
		end else if (a < ACC_LO) begin
			r = {1'b1, {(VALUE_W - 1){1'b0}}};
		end else begin
			r = a[VALUE_W-1:0];
		end
		return r;
	endfunction

	// store writes happen when a load is popped in idle
	assign q_pop  = (state_q == ST_IDLE) && !q_empty;
	assign load_a = q_pop && (q_cmd.op == OP_LOAD_A);
	assign load_b = q_pop && (q_cmd.op == OP_LOAD_B);
	assign eff_a  = q_cmd.restart ? '0 : len_a_q;
	assign eff_b  = q_cmd.restart ? '0 : len_b_q;
	assign full_a = (eff_a >= LEN_W'(MAX_TERMS));
	assign full_b = (eff_b >= LEN_W'(MAX_TERMS));
	assign we_a   = load_a && !full_a;
	assign we_b   = load_b && !full_b;

	// result length and per-coefficient term range
	assign la_p = POW_W'(len_a_q);
	assign lb_p = POW_W'(len_b_q);
	always_comb begin
		if (q_cmd.op == OP_PROD) begin
			n_new = (len_a_q == '0 || len_b_q == '0) ? '0 : la_p + lb_p - 1'b1;
		end else begin
			n_new = (la_p > lb_p) ? la_p : lb_p;
		end
	end
	assign lo_p = (k_q >= lb_p) ? k_q - lb_p + 1'b1 : '0;
	assign hi_p = (k_q >= la_p - 1'b1) ? la_p - 1'b1 : k_q;

	// sum reads a[k] and b[k]; product reads a[i] and b[k-i]
	assign raddr_a = i_q;
	assign raddr_b = prod_q ? IDX_W'(k_q - POW_W'(i_q)) : k_q[IDX_W-1:0];

	assign a_s1 = $signed(rdata_a);
	assign b_s1 = $signed(rdata_b);
	assign sa   = ma_s1 ? a_s1 : '0;
	assign sb   = mb_s1 ? b_s1 : '0;

	assign is_last   = empty_q || (k_q == n_q - 1'b1);
	assign slot_free = !out_v_q || res.ready;

	pam_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (eff_a[IDX_W-1:0]),
		.wdata (q_cmd.coef),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	pam_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (eff_b[IDX_W-1:0]),
		.wdata (q_cmd.coef),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// mac datapath: read data -> term register -> accumulator
	always_ff @(posedge clk) begin
		if (prod_s1) begin
			term_s2 <= TERM_W'(a_s1) * TERM_W'(b_s1);
		end else begin
			term_s2 <= {{(TERM_W - COEF_W){sa[COEF_W-1]}}, sa}
				+ {{(TERM_W - COEF_W){sb[COEF_W-1]}}, sb};
		end
		ma_s1   <= prod_q || (k_q < la_p);
		mb_s1   <= prod_q || (k_q < lb_p);
		prod_s1 <= prod_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			len_a_q       <= '0;
			len_b_q       <= '0;
			ovf_q         <= 1'b0;
			prod_q        <= 1'b0;
			empty_q       <= 1'b0;
			n_q           <= '0;
			k_q           <= '0;
			i_q           <= '0;
			hi_q          <= '0;
			acc_q         <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			out_v_q       <= 1'b0;
			out_value_q   <= '0;
			out_power_q   <= '0;
			out_last_q    <= 1'b0;
			out_dropped_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_ISSUE);
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= acc_q + {{(ACC_W - TERM_W){term_s2[TERM_W-1]}}, term_s2};
			end
			if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.op)
							OP_LOAD_A: begin
								if (full_a) begin
									ovf_q <= 1'b1;
								end else begin
									len_a_q <= eff_a + 1'b1;
								end
							end
							OP_LOAD_B: begin
								if (full_b) begin
									ovf_q <= 1'b1;
								end else begin
									len_b_q <= eff_b + 1'b1;
								end
							end
							OP_SUM, OP_PROD: begin
								prod_q  <= (q_cmd.op == OP_PROD);
								n_q     <= n_new;
								k_q     <= '0;
								acc_q   <= '0;
								empty_q <= (n_new == '0);
								state_q <= (n_new == '0) ? ST_EMIT : ST_SETUP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SETUP: begin
					acc_q <= '0;
					if (prod_q) begin
						i_q  <= lo_p[IDX_W-1:0];
						hi_q <= hi_p[IDX_W-1:0];
					end else begin
						i_q  <= k_q[IDX_W-1:0];
						hi_q <= k_q[IDX_W-1:0];
					end
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					if (i_q == hi_q) begin
						state_q <= ST_DRAIN;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_v_q       <= 1'b1;
						out_value_q   <= sat_value(acc_q);
						out_power_q   <= empty_q ? '0 : k_q;
						out_last_q    <= is_last;
						out_dropped_q <= ovf_q;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_SETUP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid   = out_v_q;
	assign res.value   = out_value_q;
	assign res.power   = out_power_q;
	assign res.last    = out_last_q;
	assign res.dropped = out_dropped_q;

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_a_q <= LEN_W'(MAX_TERMS) && len_b_q <= LEN_W'(MAX_TERMS))
		else $error("store length beyond capacity");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("dropped flag cleared without reset");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> i_q <= hi_q)
		else $error("term index ran past range end");
`endif

endmodule

@@ design/polynomial_add_multiply_unit.sv @@
// ----------------------------------------------------------------------------
// polynomial_add_multiply_unit
// Load beats are written to the stores while the back end is idle; each input beat passes
// through the front register and the queue first. Each result coefficient sums t terms
// (1 for a sum, up to 32 for a product), issued in turn on the single multiply-accumulate
// path with one read port per store.
// Commands run one at a time.
// Reset is asynchronous, active low; it empties both stores and clears the dropped flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polynomial_add_multiply_unit (
	input  logic  clk,
	input  logic  arst_n,
	pam_in_if.sink    cmd,
	pam_out_if.source res
);
	import pam_pkg::*;

	// front to queue
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// queue to back end
	logic pop;
	cmd_t pop_cmd;
	logic q_empty;

	// front: takes command beats and decodes the action
	pam_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_full (q_full),
		.q_push (push),
		.q_cmd  (push_cmd)
	);

	// short queue so the front can keep taking beats while a product runs, until the queue is full
	pam_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// back end: stores, lengths, mac sequencer, result register
	pam_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (pop_cmd),
		.q_pop   (pop),
		.res     (res)
	);

endmodule
